// ===== design/mldf_pkg.sv =====
// Shared types and constants for the magic word / length prefixed deframer.
// Used by mldf_ctrl, mldf_dpath and magic_length_deframer_unit.
package mldf_pkg;

    localparam int HDR_BYTES   = 8;
    localparam int MAGIC_BYTES = 4;
    localparam int FILL_W      = 4;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    // configuration register indexes
    localparam logic REG_MAGIC_WORD  = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    // controller commands to the datapath
    typedef struct packed {
        logic load_hdr;
        logic load_pay;
        logic drop_one;
        logic drop_four;
        logic clear_hdr;
        logic start_pay;
        logic emit_empty;
    } mldf_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic in_payload;
        logic prefix_ok;
        logic hdr_full;
        logic len_over;
        logic len_zero;
        logic out_free;
    } mldf_stat_t;

endpackage

// ===== design/mldf_ctrl.sv =====
// Controller state machine for the deframer: accepts bytes and steps the header search.
// Depends on mldf_pkg for the command and status structs.
module mldf_ctrl
    import mldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  mldf_stat_t stat,
    output mldf_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.in_payload)
                    begin
                        cmd.load_pay = 1'b1;
                    end
                    else
                    begin
                        cmd.load_hdr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (!stat.prefix_ok)
                begin
                    // drop the front byte and look again
                    cmd.drop_one = 1'b1;
                end
                else if (!stat.hdr_full)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.len_over)
                begin
                    // corrupt length: drop the magic, search the rest
                    cmd.drop_four = 1'b1;
                end
                else
                begin
                    cmd.clear_hdr = 1'b1;
                    if (stat.len_zero)
                        cmd.emit_empty = 1'b1;
                    else
                        cmd.start_pay = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/mldf_dpath.sv =====
// Datapath for the deframer: config registers, header shift store, payload counter,
// drop counter and output register. Depends on mldf_pkg.
module mldf_dpath
    import mldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  in_byte,
    input  mldf_cmd_t   cmd,
    output mldf_stat_t  stat,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  data_byte,
    output logic        first_byte,
    output logic        last_byte,
    output logic        empty_frame,
    output logic [31:0] dropped_total
);

    logic [31:0]       magic_reg;
    logic [31:0]       max_reg;
    logic [7:0]        store_reg [HDR_BYTES];
    logic [7:0]        store_next [HDR_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              in_pay_reg;
    logic              in_pay_next;
    logic [31:0]       left_reg;
    logic [31:0]       left_next;
    logic              at_first_reg;
    logic              at_first_next;
    logic [31:0]       drop_reg;
    logic [31:0]       drop_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       hdr_len;
    logic              match;
    logic              out_load;

    assign hdr_len = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAGIC_BYTES; i++)
        begin
            if ((fill_reg > FILL_W'(i)) && (store_reg[i] != magic_reg[8*i +: 8]))
                match = 1'b0;
        end
    end

    assign out_load = cmd.load_pay || cmd.emit_empty;

    always_comb
    begin
        stat.in_payload = in_pay_reg;
        stat.prefix_ok  = match;
        stat.hdr_full   = (fill_reg == FILL_W'(HDR_BYTES));
        stat.len_over   = (hdr_len > max_reg);
        stat.len_zero   = (hdr_len == 32'd0);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    // header store: append at the fill point, shift down on drops
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.load_hdr && (fill_reg[2:0] == 3'(i)))
                store_next[i] = in_byte;
            else if (cmd.drop_one && (i + 1 < HDR_BYTES))
                store_next[i] = store_reg[(i + 1) % HDR_BYTES];
            else if (cmd.drop_four && (i + MAGIC_BYTES < HDR_BYTES))
                store_next[i] = store_reg[(i + MAGIC_BYTES) % HDR_BYTES];
        end
    end

    always_comb
    begin
        fill_next     = fill_reg;
        drop_next     = drop_reg;
        in_pay_next   = in_pay_reg;
        left_next     = left_reg;
        at_first_next = at_first_reg;
        priority if (cmd.load_hdr)
            fill_next = fill_reg + FILL_W'(1);
        else if (cmd.drop_one)
        begin
            fill_next = fill_reg - FILL_W'(1);
            drop_next = drop_reg + 32'd1;
        end
        else if (cmd.drop_four)
        begin
            fill_next = fill_reg - FILL_W'(MAGIC_BYTES);
            drop_next = drop_reg + 32'(MAGIC_BYTES);
        end
        else if (cmd.clear_hdr)
            fill_next = '0;

        if (cmd.start_pay)
        begin
            in_pay_next   = 1'b1;
            left_next     = hdr_len;
            at_first_next = 1'b1;
        end
        else if (cmd.load_pay)
        begin
            at_first_next = 1'b0;
            if (left_reg != 32'd0)
                left_next = left_reg - 32'd1;
            if (left_reg <= 32'd1)
                in_pay_next = 1'b0;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= '0;
            max_reg       <= MAX_PAYLOAD_RST;
            fill_reg      <= '0;
            in_pay_reg    <= 1'b0;
            left_reg      <= '0;
            at_first_reg  <= 1'b0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_MAGIC_WORD))
                magic_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_MAX_PAYLOAD))
                max_reg <= cfg_data;
            fill_reg      <= fill_next;
            in_pay_reg    <= in_pay_next;
            left_reg      <= left_next;
            at_first_reg  <= at_first_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_BYTES; i++)
            store_reg[i] <= store_next[i];
        if (out_load)
        begin
            data_byte     <= cmd.load_pay ? in_byte : 8'd0;
            first_byte    <= cmd.load_pay && at_first_reg;
            last_byte     <= cmd.emit_empty || (left_reg <= 32'd1);
            empty_frame   <= cmd.emit_empty;
            dropped_total <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== design/magic_length_deframer_unit.sv =====
// Top level of the magic word / length prefixed deframer.
// Instantiates mldf_ctrl and mldf_dpath; depends on mldf_pkg.

// Takes one byte per request from a stream of frames (4 magic bytes, a 32-bit
// little-endian length, then the payload) and passes out the payload bytes with
// first/last marks, an empty-frame result for zero length, and a running count
// of dropped bytes. A payload byte is taken in the idle state and goes straight
// to the output register. A header byte is taken in the idle state; then each
// scan-state cycle shifts the 8-byte header store by one byte while hunting for
// the magic or by four on a rejected length, or ends the search. The output
// register lets a new byte in the same cycle that a waiting result is taken.
module magic_length_deframer_unit
    import mldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] data_byte, [39:8] dropped_total
    output logic [1:0]  m_tuser,    // [0] first_byte, [1] empty_frame
    output logic        m_tlast     // last_byte
);

    mldf_cmd_t   cmd;
    mldf_stat_t  stat;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        empty_frame;
    logic [31:0] dropped_total;

    mldf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mldf_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_byte       (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (m_tlast),
        .empty_frame   (empty_frame),
        .dropped_total (dropped_total)
    );

    assign m_tdata = {dropped_total, data_byte};
    assign m_tuser = {empty_frame, first_byte};

endmodule
